// ----- hw/rtl/urgency_priority_queue_unit_assert.svh -----
// Assertion macros for the urgency priority queue unit.
`ifndef URGENCY_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define URGENCY_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define UPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upq: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define UPQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upq: same-cycle check failed");

// At most one bit of the vector may be set.
`define UPQ_ASSERT_ONEHOT0(label, vec) \
    label: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vec)) \
        else $error("upq: more than one command active");

`endif

// ----- hw/rtl/upq_pkg.sv -----
// Shared types and constants of the urgency priority queue.
`default_nettype none

package upq_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int IN_W  = 40;
    localparam int OUT_W = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SERVE  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] STAT_INSERTED = 3'd0;
    localparam logic [2:0] STAT_SERVED   = 3'd1;
    localparam logic [2:0] STAT_EMPTY    = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_CLEARED  = 3'd4;

    localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SCAN,
        CS_SCAN_END,
        CS_SHIFT_INIT,
        CS_SHIFT,
        CS_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic scan_rd;
        logic shift_init;
        logic shift_rd;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic start_scan;
        logic scan_last;
        logic shift_end;
        logic slot_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/upq_ctrl.sv -----
// Sequencer of the urgency priority queue: accept, scan, compact, finish.
`default_nettype none

module upq_ctrl
    import upq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.start_scan ? CS_SCAN : CS_FINISH;
                end
            end
            CS_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = CS_SCAN_END;
                end
            end
            CS_SCAN_END:
            begin
                // last candidate is compared here
                state_next = CS_SHIFT_INIT;
            end
            CS_SHIFT_INIT:
            begin
                cmd.shift_init = 1'b1;
                state_next     = CS_SHIFT;
            end
            CS_SHIFT:
            begin
                if (stat.shift_end)
                begin
                    state_next = CS_FINISH;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                end
            end
            CS_FINISH:
            begin
                if (stat.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/upq_datapath.sv -----
// Entry memory, best-entry search, compaction and result register.
`default_nettype none

module upq_datapath
    import upq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    input  wire ctrl_cmd_t        cmd,
    output dp_stat_t              stat
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // entry layout: tag [63:48], urgency [47:32], stamp [31:0]
    logic [63:0] mem [CAPACITY];
    logic [63:0] rd_data_reg;

    logic [1:0]  op_reg;
    logic [15:0] tag_reg;
    logic [15:0] urg_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [31:0] arrival_reg;
    logic [31:0] arrival_next;
    logic [CW-1:0] ptr_reg;

    logic          scan_vld_reg;
    logic [IW-1:0] scan_idx_reg;
    logic          shift_vld_reg;
    logic [IW-1:0] shift_dst_reg;

    logic [IW-1:0] best_idx_reg;
    logic [15:0]   best_urg_reg;
    logic [31:0]   best_stamp_reg;
    logic [15:0]   best_tag_reg;

    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [15:0]   out_tag_reg;
    logic [6:0]    out_occ_reg;

    logic          rd_en;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic          take;
    logic          has_room;
    logic          is_empty;
    logic [2:0]    status_next;
    logic [15:0]   served_next;

    assign has_room = (count_reg < CW'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign rd_en    = cmd.scan_rd | cmd.shift_rd;

    // candidate beats best on higher urgency, or equal urgency and older stamp; the first candidate is always taken
    assign take = (scan_idx_reg == '0) ||
                  (rd_data_reg[47:32] > best_urg_reg) ||
                  ((rd_data_reg[47:32] == best_urg_reg) &&
                   (rd_data_reg[31:0] < best_stamp_reg));

    assign stat.start_scan = (s_tdata[1:0] == OP_SERVE) && !is_empty;
    assign stat.scan_last  = (ptr_reg == count_reg - CW'(1));
    assign stat.shift_end  = (ptr_reg == count_reg);
    assign stat.slot_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        wr_en        = 1'b0;
        wr_addr      = shift_dst_reg;
        wr_data      = rd_data_reg;
        count_next   = count_reg;
        arrival_next = (arrival_reg == STAMP_MAX) ? arrival_reg : arrival_reg + 32'd1;
        served_next  = '0;
        status_next  = STAT_CLEARED;
        case (op_reg)
            OP_INSERT:
            begin
                if (has_room)
                begin
                    status_next = STAT_INSERTED;
                    count_next  = count_reg + CW'(1);
                end
                else
                begin
                    status_next = STAT_FULL;
                end
            end
            OP_SERVE:
            begin
                if (is_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    status_next = STAT_SERVED;
                    served_next = best_tag_reg;
                    count_next  = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next  = STAT_CLEARED;
                count_next   = '0;
                arrival_next = '0;
            end
        endcase
        if (shift_vld_reg)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.commit && (op_reg == OP_INSERT) && has_room)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IW-1:0];
            wr_data = {tag_reg, urg_reg, arrival_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[ptr_reg[IW-1:0]];
        end
    end

    // payload, pointer, best-entry and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= s_tdata[1:0];
            tag_reg <= s_tdata[17:2];
            urg_reg <= s_tdata[33:18];
        end
        if (cmd.accept)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.shift_init)
        begin
            ptr_reg <= CW'(best_idx_reg) + CW'(1);
        end
        else if (rd_en)
        begin
            ptr_reg <= ptr_reg + CW'(1);
        end
        scan_idx_reg  <= ptr_reg[IW-1:0];
        shift_dst_reg <= ptr_reg[IW-1:0] - IW'(1);
        if (scan_vld_reg && take)
        begin
            best_idx_reg   <= scan_idx_reg;
            best_urg_reg   <= rd_data_reg[47:32];
            best_stamp_reg <= rd_data_reg[31:0];
            best_tag_reg   <= rd_data_reg[63:48];
        end
        if (cmd.commit)
        begin
            out_status_reg <= status_next;
            out_tag_reg    <= served_next;
            out_occ_reg    <= 7'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            arrival_reg   <= '0;
            scan_vld_reg  <= 1'b0;
            shift_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_vld_reg  <= cmd.scan_rd;
            shift_vld_reg <= cmd.shift_rd;
            if (cmd.commit)
            begin
                count_reg   <= count_next;
                arrival_reg <= arrival_next;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_occ_reg, out_tag_reg, out_status_reg};

endmodule

`default_nettype wire

// ----- hw/rtl/urgency_priority_queue_unit.sv -----
// Top level of the urgency priority queue: bounded queue served by urgency, then arrival.
// Insert, clear, serve-on-empty: accepted in idle, then finish loads the result register
// and returns to idle for the next input word; a stalled result holds the input off.
// Serve of n entries, winner in slot w: n-read scan plus a shift of the entries behind w,
// then finish loads the result register; one word in work at a time.
// Reset (rst_n, async, active low) clears state, count, arrival stamp and valid flags only.
`default_nettype none
`include "urgency_priority_queue_unit_assert.svh"

module urgency_priority_queue_unit
    import upq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input words
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // operation [1:0], request_tag [17:2], urgency [33:18], zero [39:34]
    input  wire logic [IN_W-1:0]   s_tdata,
    // result words
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // status [2:0], served_tag [18:3], occupancy [25:19], zero [31:26]
    output logic [OUT_W-1:0]       m_tdata
);

    // Command and status between sequencer and datapath.
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencer: takes a word in idle, walks the memory for serves,
    // and waits in finish until the result register can be loaded.
    upq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: entry memory with registered read, running best-entry compare,
    // one-slot shift of the entries behind the winner, count and arrival stamps,
    // and the result register that decouples the output side.
    upq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

    // A result is never loaded over one that is still waiting.
    `UPQ_ASSERT_SAME(a_commit_slot_free, cmd.commit, !m_tvalid || m_tready)

    // Sequencer drives at most one major command per cycle.
    `UPQ_ASSERT_ONEHOT0(a_cmd_onehot, {cmd.accept, cmd.scan_rd, cmd.shift_rd, cmd.commit})

    // Every accepted word moves the sequencer out of idle, which drops s_tready.
    `UPQ_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire
